// ----- hw/rtl/khcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcr_pkg
// Types, codes and typematic tables shared by the host command responder.
// ----------------------------------------------------------------------------
package khcr_pkg;

    localparam int OP_W    = 4;
    localparam int BYTE_W  = 8;
    localparam int FIRST_W = 10;
    localparam int INTER_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_SCANSET       = 4'd0;
    localparam logic [OP_W-1:0] OP_SETLEDS       = 4'd1;
    localparam logic [OP_W-1:0] OP_GETID         = 4'd2;
    localparam logic [OP_W-1:0] OP_SETRATE       = 4'd3;
    localparam logic [OP_W-1:0] OP_ENABLE        = 4'd4;
    localparam logic [OP_W-1:0] OP_RESET_DISABLE = 4'd5;
    localparam logic [OP_W-1:0] OP_RESET_DEFAULT = 4'd6;
    localparam logic [OP_W-1:0] OP_RESET_BAT     = 4'd7;
    localparam logic [OP_W-1:0] OP_RESEND        = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELFTEST = 2'd2;

    localparam logic [BYTE_W-1:0] ACK_RESET      = 8'd250;
    localparam logic [BYTE_W-1:0] ERROR_RESET    = 8'd252;
    localparam logic [BYTE_W-1:0] SELFTEST_RESET = 8'd170;

    localparam logic [BYTE_W-1:0] ID_BYTE0        = 8'hAB;
    localparam logic [BYTE_W-1:0] ID_BYTE1        = 8'h83;
    localparam logic [BYTE_W-1:0] SCAN_ARG_QUERY  = 8'd0;
    localparam logic [BYTE_W-1:0] SCAN_ARG_SET2   = 8'd2;
    localparam logic [1:0]        SCAN_SET_DEFAULT = 2'd2;

    localparam logic [FIRST_W-1:0] FIRST_DEFAULT = 10'd500;
    localparam logic [INTER_W-1:0] INTER_DEFAULT = 9'd91;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    // repeat interval in ms, indexed by bits [4:0] of the typematic byte
    localparam logic [INTER_W-1:0] INTER_TABLE [32] = '{
        9'd33,  9'd37,  9'd41,  9'd45,  9'd50,  9'd54,  9'd58,  9'd62,
        9'd66,  9'd75,  9'd83,  9'd91,  9'd100, 9'd108, 9'd116, 9'd125,
        9'd133, 9'd150, 9'd166, 9'd183, 9'd200, 9'd216, 9'd233, 9'd250,
        9'd266, 9'd300, 9'd333, 9'd366, 9'd400, 9'd433, 9'd466, 9'd500
    };

    typedef enum logic [3:0] {
        CMD_REPORT_SET,
        CMD_SELECT_SET,
        CMD_ERROR,
        CMD_SETLEDS,
        CMD_GETID,
        CMD_SETRATE,
        CMD_ENABLE,
        CMD_RESET_DISABLE,
        CMD_RESET_DEFAULT,
        CMD_RESET_BAT,
        CMD_RESEND
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [FIRST_W-1:0]   first_delay;
        logic [INTER_W-1:0]   inter_delay;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] ack;
        logic [BYTE_W-1:0] error;
        logic [BYTE_W-1:0] selftest;
    } t_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_back_state;

    function automatic logic [FIRST_W-1:0] first_delay_ms(input logic [1:0] dly);
        logic [FIRST_W-1:0] ms;
        unique case (dly)
            2'd0:    ms = 10'd250;
            2'd1:    ms = 10'd500;
            2'd2:    ms = 10'd750;
            default: ms = 10'd1000;
        endcase
        return ms;
    endfunction

endpackage

// ----- hw/rtl/khcr_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcr_in_if
// Host command channel: operation code and argument byte.
// ----------------------------------------------------------------------------
interface khcr_in_if import khcr_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data;

    modport source (output valid, operation, data, input ready);
    modport sink   (input valid, operation, data, output ready);
endinterface

// ----- hw/rtl/khcr_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcr_out_if
// Reply channel: one reply byte with the keyboard status after the command.
// ----------------------------------------------------------------------------
interface khcr_out_if import khcr_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  reply_byte;
    logic               last;
    logic               enabled;
    logic [FIRST_W-1:0] first_delay_ms;
    logic [INTER_W-1:0] inter_delay_ms;

    modport source (output valid, reply_byte, last, enabled, first_delay_ms,
                    inter_delay_ms, input ready);
    modport sink   (input valid, reply_byte, last, enabled, first_delay_ms,
                    inter_delay_ms, output ready);
endinterface

// ----- hw/rtl/khcr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcr_front
// Accepts host commands and classifies them into command records,
// with the typematic delays worked out up front.
// ----------------------------------------------------------------------------
module khcr_front import khcr_pkg::*; (
    khcr_in_if.sink i_cmd,
    input  logic    i_q_full,
    output logic    o_q_push,
    output t_cmd    o_q_cmd
);

    assign i_cmd.ready = !i_q_full;
    assign o_q_push    = i_cmd.valid && !i_q_full;

    always_comb begin
        o_q_cmd.first_delay = first_delay_ms(i_cmd.data[6:5]);
        o_q_cmd.inter_delay = INTER_TABLE[i_cmd.data[4:0]];
        unique case (i_cmd.operation)
            OP_SCANSET: begin
                if (i_cmd.data == SCAN_ARG_QUERY) begin
                    o_q_cmd.kind = CMD_REPORT_SET;
                end else if (i_cmd.data == SCAN_ARG_SET2) begin
                    o_q_cmd.kind = CMD_SELECT_SET;
                end else begin
                    o_q_cmd.kind = CMD_ERROR;
                end
            end
            OP_SETLEDS:       o_q_cmd.kind = CMD_SETLEDS;
            OP_GETID:         o_q_cmd.kind = CMD_GETID;
            OP_SETRATE:       o_q_cmd.kind = CMD_SETRATE;
            OP_ENABLE:        o_q_cmd.kind = CMD_ENABLE;
            OP_RESET_DISABLE: o_q_cmd.kind = CMD_RESET_DISABLE;
            OP_RESET_DEFAULT: o_q_cmd.kind = CMD_RESET_DEFAULT;
            OP_RESET_BAT:     o_q_cmd.kind = CMD_RESET_BAT;
            OP_RESEND:        o_q_cmd.kind = CMD_RESEND;
            default:          o_q_cmd.kind = CMD_ERROR;
        endcase
    end

endmodule

// ----- hw/rtl/khcr_cmd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcr_cmd_queue
// Short command queue between the classifier and the executing sequencer.
// ----------------------------------------------------------------------------
module khcr_cmd_queue import khcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [CMD_QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(CMD_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(CMD_QUEUE_DEPTH))
        else $error("command queue overfilled");

endmodule

// ----- hw/rtl/khcr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcr_back
// Executes queued commands: keyboard state, saved reply for resend and
// reply byte sequencing into the output register.
// ----------------------------------------------------------------------------
module khcr_back import khcr_pkg::*; #(
    parameter int REPLY_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_empty,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    khcr_out_if.source  o_rsp
);

    t_back_state        r_state, n_state;
    logic               r_enable, n_enable;
    logic [1:0]         r_scan_set, n_scan_set;
    logic [FIRST_W-1:0] r_first, n_first;
    logic [INTER_W-1:0] r_inter, n_inter;
    logic [1:0]         r_saved_cnt, n_saved_cnt;
    logic [BYTE_W-1:0]  r_saved [REPLY_DEPTH];
    logic [BYTE_W-1:0]  r_pend [2];
    logic               r_last_idx, n_last_idx;
    logic               r_idx, n_idx;

    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic               r_out_en;
    logic [FIRST_W-1:0] r_out_first;
    logic [INTER_W-1:0] r_out_inter;

    logic [1:0]         w_rep_n;
    logic [BYTE_W-1:0]  w_rep0, w_rep1;
    logic               w_save;
    logic               w_load;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.reply_byte     = r_out_byte;
    assign o_rsp.last           = r_out_last;
    assign o_rsp.enabled        = r_out_en;
    assign o_rsp.first_delay_ms = r_out_first;
    assign o_rsp.inter_delay_ms = r_out_inter;

    always_comb begin
        n_state     = r_state;
        n_enable    = r_enable;
        n_scan_set  = r_scan_set;
        n_first     = r_first;
        n_inter     = r_inter;
        n_saved_cnt = r_saved_cnt;
        n_last_idx  = r_last_idx;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        o_q_pop     = 1'b0;
        w_load      = 1'b0;
        w_save      = 1'b0;
        w_rep_n     = 2'd0;
        w_rep0      = i_cfg.error;
        w_rep1      = i_cfg.error;

        unique case (i_q_cmd.kind)
            CMD_REPORT_SET: begin
                w_rep_n = 2'd1;
                w_rep0  = {{(BYTE_W-2){1'b0}}, r_scan_set};
            end
            CMD_SELECT_SET: n_scan_set = SCAN_SET_DEFAULT;
            CMD_ERROR:      w_rep_n = 2'd1;
            CMD_SETLEDS: begin
                w_rep_n = 2'd1;
                w_rep0  = i_cfg.ack;
            end
            CMD_GETID: begin
                w_rep_n = 2'd2;
                w_rep0  = ID_BYTE0;
                w_rep1  = ID_BYTE1;
            end
            CMD_SETRATE: begin
                n_first = i_q_cmd.first_delay;
                n_inter = i_q_cmd.inter_delay;
            end
            CMD_ENABLE:     n_enable = 1'b1;
            CMD_RESET_DISABLE: begin
                n_enable = 1'b0;
                n_first  = FIRST_DEFAULT;
                n_inter  = INTER_DEFAULT;
            end
            CMD_RESET_DEFAULT: begin
                n_first = FIRST_DEFAULT;
                n_inter = INTER_DEFAULT;
            end
            CMD_RESET_BAT: begin
                n_enable = 1'b0;
                w_rep_n  = 2'd2;
                w_rep0   = i_cfg.selftest;
                w_rep1   = i_cfg.selftest;
            end
            CMD_RESEND: begin
                w_rep_n = r_saved_cnt;
                w_rep0  = r_saved[0];
                w_rep1  = r_saved[1];
            end
            default: w_rep_n = 2'd1;
        endcase

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (w_rep_n != 2'd0) begin
                        n_state    = ST_EMIT;
                        n_idx      = 1'b0;
                        n_last_idx = (w_rep_n == 2'd2);
                        if (i_q_cmd.kind != CMD_RESEND) begin
                            w_save      = 1'b1;
                            n_saved_cnt = w_rep_n;
                        end
                    end
                end else begin
                    n_enable   = r_enable;
                    n_scan_set = r_scan_set;
                    n_first    = r_first;
                    n_inter    = r_inter;
                end
            end
            ST_EMIT: begin
                n_enable   = r_enable;
                n_scan_set = r_scan_set;
                n_first    = r_first;
                n_inter    = r_inter;
                if (!r_out_valid || o_rsp.ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_idx == r_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_enable    <= 1'b0;
            r_scan_set  <= SCAN_SET_DEFAULT;
            r_first     <= FIRST_DEFAULT;
            r_inter     <= INTER_DEFAULT;
            r_saved_cnt <= 2'd0;
            r_last_idx  <= 1'b0;
            r_idx       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enable    <= n_enable;
            r_scan_set  <= n_scan_set;
            r_first     <= n_first;
            r_inter     <= n_inter;
            r_saved_cnt <= n_saved_cnt;
            r_last_idx  <= n_last_idx;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pend[0] <= w_rep0;
            r_pend[1] <= w_rep1;
        end
        if (w_save) begin
            r_saved[0] <= w_rep0;
            if (w_rep_n == 2'd2) begin
                r_saved[1] <= w_rep1;
            end
        end
        if (w_load) begin
            r_out_byte  <= r_pend[r_idx];
            r_out_last  <= (r_idx == r_last_idx);
            r_out_en    <= r_enable;
            r_out_first <= r_first;
            r_out_inter <= r_inter;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_saved_cnt != 2'd3)
        else $error("saved reply count out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx <= r_last_idx))
        else $error("reply index past last byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("reply item shown outside emission");

endmodule

// ----- hw/rtl/keyboard_host_command_responder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_host_command_responder
// Keyboard-side responder to host commands: enable flag, scan set,
// typematic delays and reply bytes with resend of the last reply.
// ----------------------------------------------------------------------------
// Flow: ST_IDLE pops a queued command and registers its reply bytes; ST_EMIT
//   loads them one by one into the output register, holding on receiver stalls,
//   before the next pop. A 2-entry command queue decouples the input.
// Reset: synchronous, active low; clears enable, restores scan set 2 and the
//   500 ms / 91 ms typematic defaults, empties the saved reply, resets codes.
module keyboard_host_command_responder import khcr_pkg::*; #(
    parameter int REPLY_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    khcr_in_if.sink               i_cmd,
    khcr_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [BYTE_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    logic w_push, w_pop, w_full, w_empty;
    t_cmd w_push_cmd, w_head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack      <= ACK_RESET;
            r_cfg.error    <= ERROR_RESET;
            r_cfg.selftest <= SELFTEST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACK:      r_cfg.ack      <= i_cfg_data;
                CFG_ERROR:    r_cfg.error    <= i_cfg_data;
                CFG_SELFTEST: r_cfg.selftest <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    khcr_front u_front (
        .i_cmd    (i_cmd),
        .i_q_full (w_full),
        .o_q_push (w_push),
        .o_q_cmd  (w_push_cmd)
    );

    khcr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    khcr_back #(
        .REPLY_DEPTH (REPLY_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_empty),
        .i_q_cmd   (w_head_cmd),
        .o_q_pop   (w_pop),
        .o_rsp     (o_rsp)
    );

endmodule

// ----- bench/khcr_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcr_reply_checker
// Watches the command, reply and code-write ports of the host command
// responder. Tracks keyboard state and reply codes, queues the reply bytes
// each accepted command should produce and compares every reply item
// against them field by field.
// ----------------------------------------------------------------------------
module khcr_reply_checker import khcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    khcr_in_if                   i_cmd,
    khcr_out_if                  i_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_reply_count
);

    typedef struct {
        logic [BYTE_W-1:0]  reply_byte;
        logic               last;
        logic               enabled;
        logic [FIRST_W-1:0] first_ms;
        logic [INTER_W-1:0] inter_ms;
    } t_reply_expect;

    t_reply_expect      expected_replies[$];
    logic [BYTE_W-1:0]  ack_code, error_code, selftest_code;
    logic               kbd_enabled;
    logic [1:0]         scan_set;
    logic [FIRST_W-1:0] start_delay;
    logic [INTER_W-1:0] repeat_gap;
    logic [BYTE_W-1:0]  last_reply[2];
    int                 last_reply_len;
    int                 mismatches;
    int                 replies_seen;

    assign o_fail_count  = mismatches;
    assign o_reply_count = replies_seen;

    // keyboard state update and reply bytes for one host command
    function automatic void answer_command(input logic [OP_W-1:0] op,
                                           input logic [BYTE_W-1:0] arg);
        logic [BYTE_W-1:0] bytes[2];
        int                len;
        bit                keep;
        t_reply_expect     e;
        len  = 0;
        keep = 1'b1;
        case (op)
            OP_SCANSET: begin
                if (arg == SCAN_ARG_QUERY) begin
                    bytes[0] = {6'd0, scan_set};
                    len = 1;
                end else if (arg == SCAN_ARG_SET2) begin
                    scan_set = SCAN_SET_DEFAULT;
                end else begin
                    bytes[0] = error_code;
                    len = 1;
                end
            end
            OP_SETLEDS: begin
                bytes[0] = ack_code;
                len = 1;
            end
            OP_GETID: begin
                bytes[0] = ID_BYTE0;
                bytes[1] = ID_BYTE1;
                len = 2;
            end
            OP_SETRATE: begin
                start_delay = FIRST_W'((int'(arg[6:5]) + 1) * 250);
                repeat_gap  = INTER_W'((1000 * (1 << arg[4:3]) * (int'(arg[2:0]) + 8))
                                       / 240);
            end
            OP_ENABLE: kbd_enabled = 1'b1;
            OP_RESET_DISABLE: begin
                kbd_enabled = 1'b0;
                start_delay = FIRST_DEFAULT;
                repeat_gap  = INTER_DEFAULT;
            end
            OP_RESET_DEFAULT: begin
                start_delay = FIRST_DEFAULT;
                repeat_gap  = INTER_DEFAULT;
            end
            OP_RESET_BAT: begin
                kbd_enabled = 1'b0;
                bytes[0] = selftest_code;
                bytes[1] = selftest_code;
                len = 2;
            end
            OP_RESEND: begin
                keep = 1'b0;
                for (int k = 0; k < last_reply_len; k++) bytes[k] = last_reply[k];
                len = last_reply_len;
            end
            default: begin
                bytes[0] = error_code;
                len = 1;
            end
        endcase
        if (len > 0 && keep) begin
            for (int k = 0; k < len; k++) last_reply[k] = bytes[k];
            last_reply_len = len;
        end
        for (int k = 0; k < len; k++) begin
            e.reply_byte = bytes[k];
            e.last       = (k == len - 1);
            e.enabled    = kbd_enabled;
            e.first_ms   = start_delay;
            e.inter_ms   = repeat_gap;
            expected_replies.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply_expect e;
        if (!i_rst_n) begin
            ack_code       = ACK_RESET;
            error_code     = ERROR_RESET;
            selftest_code  = SELFTEST_RESET;
            kbd_enabled    = 1'b0;
            scan_set       = SCAN_SET_DEFAULT;
            start_delay    = FIRST_DEFAULT;
            repeat_gap     = INTER_DEFAULT;
            last_reply_len = 0;
            expected_replies.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected reply byte %02h, nothing pending",
                                 $realtime, i_rsp.reply_byte);
                end else begin
                    e = expected_replies.pop_front();
                    if (i_rsp.reply_byte !== e.reply_byte || i_rsp.last !== e.last ||
                        i_rsp.enabled !== e.enabled || i_rsp.first_delay_ms !== e.first_ms ||
                        i_rsp.inter_delay_ms !== e.inter_ms) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: reply mismatch: expected byte %02h last %0b en %0b %0d %0d",
                                     $realtime, e.reply_byte, e.last, e.enabled,
                                     e.first_ms, e.inter_ms);
                            $display("    got byte %02h last %0b en %0b first %0d inter %0d",
                                     i_rsp.reply_byte, i_rsp.last, i_rsp.enabled,
                                     i_rsp.first_delay_ms, i_rsp.inter_delay_ms);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACK:      ack_code      = i_cfg_data;
                    CFG_ERROR:    error_code    = i_cfg_data;
                    CFG_SELFTEST: selftest_code = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) answer_command(i_cmd.operation, i_cmd.data);
        end
        o_pending <= expected_replies.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the keyboard host command responder. A directed pass covers
// every command, scan-set selector cases, typematic extremes and resend with
// and without a saved reply; random commands then run under several reply
// code settings with bursty input, a stalling receiver and long hold-offs.
// ----------------------------------------------------------------------------
module tb;
    import khcr_pkg::*;

    localparam logic [OP_W-1:0] OP_UNSUPPORTED = 4'd9;
    localparam logic [OP_W-1:0] OP_TOP_CODE    = {OP_W{1'b1}};
    localparam int ITEMS_PER_PHASE  = 230;
    localparam int NUM_PHASES       = 5;
    localparam int SETTLE_CYCLES    = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 500000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;
    int                   reply_count;
    int                   sent_count;
    int                   cycle_count;
    int                   burst_left;
    bit                   long_hold;

    khcr_in_if  cmd ();
    khcr_out_if rsp ();

    keyboard_host_command_responder i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd),
        .o_rsp      (rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    khcr_reply_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd         (cmd),
        .i_rsp         (rsp),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_reply_count (reply_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
        $display("Some tests failed");
        $finish;
    end

    // receiver: ready pattern changes every stretch, long hold-off on request
    initial begin
        int stretch;
        int mode;
        rsp.ready = 1'b0;
        stretch   = 0;
        mode      = 0;
        forever begin
            @(negedge clk);
            if (long_hold) begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(16, 128);
                    mode    = $urandom_range(0, 3);
                end
                stretch--;
                case (mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp.ready <= 1'($urandom_range(0, 1));
                    default: rsp.ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    task automatic send_command(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] arg);
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.data      <= arg;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic wait_replies_done();
        cmd.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_codes(input logic [BYTE_W-1:0] ack, input logic [BYTE_W-1:0] err,
                              input logic [BYTE_W-1:0] selftest);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ACK;
        cfg_data <= ack;
        @(negedge clk);
        cfg_idx  <= CFG_ERROR;
        cfg_data <= err;
        @(negedge clk);
        cfg_idx  <= CFG_SELFTEST;
        cfg_data <= selftest;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic pick_command(output logic [OP_W-1:0] op, output logic [BYTE_W-1:0] arg);
        int r;
        r   = $urandom_range(0, 99);
        arg = BYTE_W'($urandom_range(0, 255));
        if (r < 12) begin
            op = OP_SCANSET;
            case ($urandom_range(0, 3))
                0: arg = SCAN_ARG_QUERY;
                1: arg = SCAN_ARG_SET2;
                default: ;
            endcase
        end
        else if (r < 22) op = OP_SETLEDS;
        else if (r < 32) op = OP_GETID;
        else if (r < 46) op = OP_SETRATE;
        else if (r < 54) op = OP_ENABLE;
        else if (r < 60) op = OP_RESET_DISABLE;
        else if (r < 66) op = OP_RESET_DEFAULT;
        else if (r < 74) op = OP_RESET_BAT;
        else if (r < 88) op = OP_RESEND;
        else if (r < 94) op = OP_UNSUPPORTED;
        else op = OP_W'($urandom_range(int'(OP_UNSUPPORTED) + 1, int'(OP_TOP_CODE)));
    endtask

    initial begin
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] arg;
        cmd.valid     = 1'b0;
        cmd.operation = OP_SCANSET;
        cmd.data      = '0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_ACK;
        cfg_data      = '0;
        rst_n         = 1'b0;
        sent_count    = 0;
        burst_left    = 0;
        long_hold     = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass under reset codes
        send_command(OP_RESEND, 8'h00);               // nothing saved yet
        send_command(OP_SCANSET, SCAN_ARG_QUERY);
        send_command(OP_SCANSET, 8'h01);
        send_command(OP_SCANSET, 8'hFF);
        send_command(OP_RESEND, 8'hFF);               // replays the error byte
        send_command(OP_SCANSET, SCAN_ARG_SET2);
        send_command(OP_SETLEDS, 8'hFF);
        send_command(OP_GETID, 8'h00);
        send_command(OP_RESEND, 8'h5A);               // two-byte replay
        send_command(OP_RESEND, 8'hA5);               // replay is not re-saved
        send_command(OP_SETRATE, 8'h00);
        send_command(OP_SETLEDS, 8'h00);
        send_command(OP_SETRATE, 8'h7F);
        send_command(OP_ENABLE, 8'h00);
        send_command(OP_SETLEDS, 8'h00);
        send_command(OP_SETRATE, 8'hFF);              // bit 7 ignored
        send_command(OP_RESET_DEFAULT, 8'h00);
        send_command(OP_GETID, 8'hFF);
        send_command(OP_RESET_DISABLE, 8'hFF);
        send_command(OP_SETLEDS, 8'h00);
        send_command(OP_RESET_BAT, 8'h00);
        send_command(OP_RESEND, 8'h00);
        send_command(OP_UNSUPPORTED, 8'hAA);
        send_command(OP_TOP_CODE, 8'h55);
        send_command(OP_SCANSET, SCAN_ARG_QUERY);
        wait_replies_done();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                1: load_codes(8'h00, 8'h00, 8'h00);
                2: load_codes(8'hFF, 8'hFF, 8'hFF);
                3, 4: load_codes(BYTE_W'($urandom_range(0, 255)),
                                 BYTE_W'($urandom_range(0, 255)),
                                 BYTE_W'($urandom_range(0, 255)));
                default: ;
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ((phase == 1 || phase == 3) && i == 40) long_hold = 1'b1;
                pick_command(op, arg);
                send_command(op, arg);
                if ($urandom_range(0, 99) == 0) wait_replies_done();
                else pace_sender();
            end
            wait_replies_done();
        end

        $display("Ran %0d host commands: every operation, reserved codes, resend cases,",
                 sent_count);
        $display("%0d reply bytes compared over %0d reply-code settings with stalls and hold-offs",
                 reply_count, NUM_PHASES);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/khcr_pkg.sv
hw/rtl/khcr_in_if.sv
hw/rtl/khcr_out_if.sv
hw/rtl/khcr_front.sv
hw/rtl/khcr_cmd_queue.sv
hw/rtl/khcr_back.sv
hw/rtl/keyboard_host_command_responder.sv
bench/khcr_reply_checker.sv
bench/tb.sv
